/* src/rbsi_pkg.sv */
`default_nettype none
package rbsi_pkg;

   localparam int DW           = 32;
   localparam int HALF_W       = 31;
   localparam int DIFF_W       = 35;
   localparam int RECIP_STAGES = 16;  // two quotient bits per stage
   localparam int RECIP_LAT    = RECIP_STAGES + 2;
   localparam int PIPE_LAT     = RECIP_LAT + 5;
   localparam int REQ_W        = 384;
   localparam int RSP_W        = 72;

   localparam logic signed [DW-1:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [DW-1:0] Q_MIN = 32'sh80000000;

endpackage
`default_nettype wire

/* src/rbsi_recip.sv */
`default_nettype none
module rbsi_recip #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic signed [rbsi_pkg::DW-1:0] dir,
   output logic signed [rbsi_pkg::DW-1:0]      recip
);
   localparam int NSTG = rbsi_pkg::RECIP_STAGES;
   localparam logic [63:0] NUM = 64'd1 << (2 * FRAC_BITS);

   logic [31:0] rem_ff  [0:NSTG];
   logic [31:0] q_ff    [0:NSTG];
   logic [31:0] m_ff    [0:NSTG];
   logic        neg_ff  [0:NSTG];
   logic        zero_ff [0:NSTG];
   logic        sat_ff  [0:NSTG];
   logic signed [31:0] recip_ff;
   logic signed [31:0] recip_in;

   logic [31:0] mag_in;
   logic [63:0] m_sh;
   logic        sat_in;

   always_comb begin
      mag_in = dir[31] ? (~dir + 32'd1) : dir;
      m_sh   = {32'd0, mag_in} << 31;
      // quotient would not fit the signed result range
      sat_in = dir[31] ? ((m_sh + {32'd0, mag_in}) <= NUM) : (m_sh <= NUM);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= NUM[63:32];
         q_ff[0]    <= 32'd0;
         m_ff[0]    <= mag_in;
         neg_ff[0]  <= dir[31];
         zero_ff[0] <= (dir == 32'sd0);
         sat_ff[0]  <= sat_in;
      end
   end

   for (genvar k = 1; k <= NSTG; k++) begin : g_stage
      localparam int B1 = 31 - 2 * (k - 1);
      localparam int B0 = B1 - 1;
      logic [32:0] r1;
      logic [32:0] r2;
      logic [31:0] r1s;
      logic [31:0] rem_in;
      logic        ge1;
      logic        ge0;

      always_comb begin
         r1     = {rem_ff[k-1], NUM[B1]};
         ge1    = r1 >= {1'b0, m_ff[k-1]};
         r1s    = ge1 ? 32'(r1 - {1'b0, m_ff[k-1]}) : r1[31:0];
         r2     = {r1s, NUM[B0]};
         ge0    = r2 >= {1'b0, m_ff[k-1]};
         rem_in = ge0 ? 32'(r2 - {1'b0, m_ff[k-1]}) : r2[31:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            q_ff[k]    <= {q_ff[k-1][29:0], ge1, ge0};
            m_ff[k]    <= m_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
         end
      end
   end

   always_comb begin
      if (zero_ff[NSTG]) begin
         recip_in = rbsi_pkg::Q_MAX;
      end else if (sat_ff[NSTG]) begin
         recip_in = neg_ff[NSTG] ? rbsi_pkg::Q_MIN : rbsi_pkg::Q_MAX;
      end else if (neg_ff[NSTG]) begin
         recip_in = $signed(~q_ff[NSTG] + 32'd1);
      end else begin
         recip_in = $signed(q_ff[NSTG]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         recip_ff <= recip_in;
      end
   end

   assign recip = recip_ff;
endmodule
`default_nettype wire

/* src/rbsi_mulq.sv */
`default_nettype none
module rbsi_mulq #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic [rbsi_pkg::DIFF_W-1:0]       a_mag,
   input  wire logic [rbsi_pkg::DW-1:0]           b_mag,
   input  wire logic                              neg,
   output logic signed [rbsi_pkg::DW-1:0]         prod
);
   localparam int SUM_W = rbsi_pkg::DIFF_W + rbsi_pkg::DW;

   logic [63:0]        pl_ff;
   logic [34:0]        ph_ff;
   logic               neg_ff;
   logic signed [31:0] prod_ff;
   logic signed [31:0] prod_in;
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]   mag;

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff  <= {32'd0, a_mag[31:0]} * {32'd0, b_mag};
         ph_ff  <= {32'd0, a_mag[34:32]} * {3'd0, b_mag};
         neg_ff <= neg;
      end
   end

   always_comb begin
      sum = {ph_ff, 32'd0} + {3'd0, pl_ff};
      mag = sum >> FRAC_BITS;
      if (neg_ff) begin
         prod_in = (mag > SUM_W'(64'h80000000)) ? rbsi_pkg::Q_MIN
                                                 : $signed(32'(~mag + 1'b1));
      end else begin
         prod_in = (mag > SUM_W'(64'h7fffffff)) ? rbsi_pkg::Q_MAX
                                                 : $signed(mag[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

/* src/rbsi_axis.sv */
`default_nettype none
module rbsi_axis #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic signed [rbsi_pkg::DW-1:0]    origin,
   input  wire logic signed [rbsi_pkg::DW-1:0]    direction,
   input  wire logic signed [rbsi_pkg::DW-1:0]    center,
   input  wire logic [rbsi_pkg::HALF_W-1:0]       half,
   output logic signed [rbsi_pkg::DW-1:0]         lo,
   output logic signed [rbsi_pkg::DW-1:0]         hi
);
   localparam int DL = rbsi_pkg::RECIP_LAT;
   localparam int AW = rbsi_pkg::DIFF_W;

   logic signed [AW-1:0] dmin_ff [0:DL-1];
   logic signed [AW-1:0] dmax_ff [0:DL-1];
   logic signed [AW-1:0] c_e, o_e, h_e;
   logic signed [31:0]   r;
   logic signed [AW-1:0] a_lo, a_hi, dmin_d, dmax_d;
   logic [AW-1:0]        ma_lo_ff, ma_hi_ff;
   logic [31:0]          mb_ff;
   logic                 nlo_ff, nhi_ff;

   rbsi_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
      .clock (clock),
      .en    (en),
      .dir   (direction),
      .recip (r)
   );

   always_comb begin
      c_e = AW'(center);
      o_e = AW'(origin);
      h_e = $signed({4'd0, half});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dmin_ff[0] <= c_e - h_e - o_e;
         dmax_ff[0] <= c_e + h_e - o_e;
         for (int i = 1; i < DL; i++) begin
            dmin_ff[i] <= dmin_ff[i-1];
            dmax_ff[i] <= dmax_ff[i-1];
         end
      end
   end

   always_comb begin
      dmin_d = dmin_ff[DL-1];
      dmax_d = dmax_ff[DL-1];
      // negative reciprocal swaps the slab ends
      a_lo = r[31] ? dmax_d : dmin_d;
      a_hi = r[31] ? dmin_d : dmax_d;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_lo_ff <= a_lo[AW-1] ? (~a_lo + 1'b1) : a_lo;
         ma_hi_ff <= a_hi[AW-1] ? (~a_hi + 1'b1) : a_hi;
         mb_ff    <= r[31] ? (~r + 32'd1) : r;
         nlo_ff   <= a_lo[AW-1] ^ r[31];
         nhi_ff   <= a_hi[AW-1] ^ r[31];
      end
   end

   rbsi_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_lo (
      .clock (clock),
      .en    (en),
      .a_mag (ma_lo_ff),
      .b_mag (mb_ff),
      .neg   (nlo_ff),
      .prod  (lo)
   );

   rbsi_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_hi (
      .clock (clock),
      .en    (en),
      .a_mag (ma_hi_ff),
      .b_mag (mb_ff),
      .neg   (nhi_ff),
      .prod  (hi)
   );
endmodule
`default_nettype wire

/* src/ray_box_slab_intersect_top.sv */
// Ray versus axis-aligned box, slab test, fully pipelined.
// req channel: one ray-box pair per transaction (origin, direction, box
//   center as signed fixed point, half extents unsigned).
// rsp channel: one result per transaction: hit flag, entry and exit
//   distances, both zero on a miss.
// One transaction per cycle sustained while the output is not stalled.
//   The depth from req acceptance to rsp_tvalid is set by the reciprocal
//   divider, which resolves two quotient bits per stage over 16 stages,
//   plus operand prep, two multiply stages and two interval-merge stages.
// All three axes run side by side; items never interact.
// Reset clears every valid bit; no result is pending after reset.
// When rsp_tready is low with a result waiting, the whole pipeline holds
//   and req_tready drops; bubbles ahead of the output keep filling only
//   while the output register is free. Nothing is lost or repeated.
`default_nettype none
module ray_box_slab_intersect_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
   // box_center_x, box_center_y, box_center_z, half_size_x, half_size_y,
   // half_size_z, zero pad
   input  wire logic [rbsi_pkg::REQ_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // hit, entry_dist, exit_dist, zero pad
   output logic [rbsi_pkg::RSP_W-1:0]        rsp_tdata
);
   localparam int LAT = rbsi_pkg::PIPE_LAT;

   logic [LAT-1:0]     vld_ff;
   logic               en;
   logic signed [31:0] lo [0:2];
   logic signed [31:0] hi [0:2];

   logic               miss1_ff;
   logic signed [31:0] tmin_ff, tmax_ff, zlo_ff, zhi_ff;
   logic signed [31:0] tmin_in, tmax_in;
   logic               hit_ff;
   logic signed [31:0] entry_ff, exit_ff;
   logic               hit_in;

   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbsi_axis #(.FRAC_BITS(FRAC_BITS)) u_axis (
         .clock     (clock),
         .en        (en),
         .origin    ($signed(req_tdata[32*a +: 32])),
         .direction ($signed(req_tdata[96 + 32*a +: 32])),
         .center    ($signed(req_tdata[192 + 32*a +: 32])),
         .half      (req_tdata[288 + 31*a +: 31]),
         .lo        (lo[a]),
         .hi        (hi[a])
      );
   end

   always_comb begin
      tmin_in = (lo[1] > lo[0]) ? lo[1] : lo[0];
      tmax_in = (hi[1] < hi[0]) ? hi[1] : hi[0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         miss1_ff <= (lo[0] > hi[1]) || (lo[1] > hi[0]);
         tmin_ff  <= tmin_in;
         tmax_ff  <= tmax_in;
         zlo_ff   <= lo[2];
         zhi_ff   <= hi[2];
      end
   end

   assign hit_in = !miss1_ff && !((tmin_ff > zhi_ff) || (zlo_ff > tmax_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff   <= hit_in;
         entry_ff <= !hit_in ? 32'sd0 : ((zlo_ff > tmin_ff) ? zlo_ff : tmin_ff);
         exit_ff  <= !hit_in ? 32'sd0 : ((zhi_ff < tmax_ff) ? zhi_ff : tmax_ff);
      end
   end

   assign rsp_tdata = {7'd0, exit_ff, entry_ff, hit_ff};

`ifndef SYNTHESIS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[64:1] == 64'd0)
      else $error("miss result with nonzero distances");

   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> $signed(rsp_tdata[32:1]) <= $signed(rsp_tdata[64:33]))
      else $error("hit with entry after exit");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

   typedef struct packed {
      logic [30:0] hz, hy, hx;
      logic [31:0] cz, cy, cx;
      logic [31:0] dz, dy, dx;
      logic [31:0] oz, oy, ox;
   } ray_box_type;

   typedef struct packed {
      logic [31:0] exit_d;
      logic [31:0] entry_d;
      logic        hit;
   } slab_hit_type;

   localparam int FB = 16;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [rbsi_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [rbsi_pkg::RSP_W-1:0] rsp_tdata;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   slab_hit_type hit_queue[$];

   ray_box_slab_intersect_top #(.FRAC_BITS(FB)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial forever #2 clock = ~clock;

   initial begin
      #20000000;
      $display("tb_top: errors");
      $finish;
   end

   function automatic longint sat32(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   function automatic longint fx_recip(longint d);
      longint one;
      one = 64'sd1 <<< (2 * FB);
      if (d == 0) return QMAX;
      return sat32(one / d);
   endfunction

   // magnitude product, truncated toward zero, then saturated
   function automatic longint fx_mul(longint a, longint b);
      logic neg;
      logic [127:0] m;
      logic [127:0] ma, mb;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m = (ma * mb) >> FB;
      if (neg) return (m > 128'd2147483648) ? QMIN : -longint'(m);
      return (m > 128'd2147483647) ? QMAX : longint'(m);
   endfunction

   function automatic void slab_bounds(input logic [31:0] o, d, c, input logic [30:0] h,
                                       output longint lo, output longint hi);
      longint r, dmin, dmax;
      r = fx_recip(longint'($signed(d)));
      dmin = longint'($signed(c)) - longint'(h) - longint'($signed(o));
      dmax = longint'($signed(c)) + longint'(h) - longint'($signed(o));
      if (r >= 0) begin
         lo = fx_mul(dmin, r); hi = fx_mul(dmax, r);
      end else begin
         lo = fx_mul(dmax, r); hi = fx_mul(dmin, r);
      end
   endfunction

   function automatic slab_hit_type predict_hit(ray_box_type q);
      longint tmin, tmax, lo, hi;
      slab_hit_type res;
      res.hit = 1'b1;
      slab_bounds(q.ox, q.dx, q.cx, q.hx, tmin, tmax);
      slab_bounds(q.oy, q.dy, q.cy, q.hy, lo, hi);
      if (tmin > hi || lo > tmax) begin
         res.hit = 1'b0;
      end else begin
         if (lo > tmin) tmin = lo;
         if (hi < tmax) tmax = hi;
         slab_bounds(q.oz, q.dz, q.cz, q.hz, lo, hi);
         if (tmin > hi || lo > tmax) begin
            res.hit = 1'b0;
         end else begin
            if (lo > tmin) tmin = lo;
            if (hi < tmax) tmax = hi;
         end
      end
      if (!res.hit) begin
         tmin = 0; tmax = 0;
      end
      res.entry_d = tmin[31:0];
      res.exit_d = tmax[31:0];
      return res;
   endfunction

   // req_tvalid stays high from one transaction to the next unless idling
   task automatic send_ray(input ray_box_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'd0, q};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hit_queue.push_back(predict_hit(q));
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      slab_hit_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = slab_hit_type'(rsp_tdata[64:0]);
         if (hit_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = hit_queue.pop_front();
            if (got.hit !== want.hit || got.entry_d !== want.entry_d
                || got.exit_d !== want.exit_d) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp hit=%0b in=%h out=%h got hit=%0b in=%h out=%h",
                           want.hit, want.entry_d, want.exit_d,
                           got.hit, got.entry_d, got.exit_d);
            end
         end
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(8 << FB)) - (4 << FB));
         2: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return 32'($signed($urandom_range(200 << FB)) - (100 << FB));
      endcase
   endfunction

   function automatic logic [31:0] rand_dir();
      case ($urandom_range(7))
         0: return 32'h0;
         1: return $urandom;
         2: return 32'($signed($urandom_range(6)) - 3);
         3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return 32'($signed($urandom_range(4 << FB)) - (2 << FB));
      endcase
   endfunction

   function automatic logic [30:0] rand_half();
      case ($urandom_range(4))
         0: return 31'($urandom);
         1: return $urandom_range(1) ? 31'h7fff_ffff : 31'h0;
         default: return 31'($urandom_range(50 << FB));
      endcase
   endfunction

   // with aimed set, each center coordinate is offset from the origin by a small random multiple of that axis direction
   function automatic ray_box_type rand_ray(bit aimed);
      ray_box_type q;
      q.ox = rand_coord(); q.oy = rand_coord(); q.oz = rand_coord();
      q.dx = rand_dir(); q.dy = rand_dir(); q.dz = rand_dir();
      q.cx = rand_coord(); q.cy = rand_coord(); q.cz = rand_coord();
      q.hx = rand_half(); q.hy = rand_half(); q.hz = rand_half();
      if (aimed) begin
         q.cx = q.ox + 32'($signed($urandom_range(40)) - 20) * q.dx;
         q.cy = q.oy + 32'($signed($urandom_range(40)) - 20) * q.dy;
         q.cz = q.oz + 32'($signed($urandom_range(40)) - 20) * q.dz;
      end
      return q;
   endfunction

   task automatic test_directed();
      ray_box_type q;
      q = '0;
      q.dx = 32'h0001_0000; q.dy = 32'h0001_0000; q.dz = 32'h0001_0000;
      q.cx = 32'h0005_0000; q.cy = 32'h0005_0000; q.cz = 32'h0005_0000;
      q.hx = 31'h0001_0000; q.hy = 31'h0001_0000; q.hz = 31'h0001_0000;
      send_ray(q);                      // plain hit
      q.dx = 32'hffff_0000; send_ray(q); // negative reciprocal
      q.dx = 32'h0; send_ray(q);         // zero direction
      q.dx = 32'h7fff_ffff; send_ray(q); // reciprocal truncates to 2 LSB
      q.dx = 32'h8000_0000; send_ray(q);
      q.dx = 32'h0000_0001; send_ray(q); // reciprocal saturates
      q.dx = 32'hffff_ffff; send_ray(q);
      q.cy = 32'h8000_0000; send_ray(q); // miss, detected on z
      q.cy = 32'h0005_0000; q.cz = 32'h8000_0000; send_ray(q); // miss, detected on y
      q = '1; send_ray(q);
      q = '0; send_ray(q);
      q.ox = 32'h8000_0000; q.oy = 32'h7fff_ffff; q.oz = 32'h8000_0000;
      q.cx = 32'h7fff_ffff; q.cy = 32'h8000_0000; q.cz = 32'h7fff_ffff;
      q.hx = '1; q.hy = '1; q.hz = '1;
      q.dx = 32'h0000_0100; q.dy = 32'hffff_ff00; q.dz = 32'h0000_0001;
      send_ray(q);                       // product saturation
      q.dx = 32'h8000_0000; q.dy = 32'h7fff_ffff; q.dz = 32'h0;
      send_ray(q);
   endtask

   task automatic test_random(int n, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (n) send_ray(rand_ray($urandom_range(99) < 75));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(500, 0, 0);
      test_random(450, 58, 0);
      test_random(450, 0, 58);
      test_random(450, 11, 11);
      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (rbsi_pkg::PIPE_LAT + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
